// ----- hw/rtl/conv3x3_image_filter_core_macros.svh -----
// Assertion macros shared by the filter RTL.
`ifndef CONV3X3_IMAGE_FILTER_CORE_MACROS_SVH
`define CONV3X3_IMAGE_FILTER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define C3_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define C3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define C3_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define C3_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/c3f_pkg.sv -----
// Shared types and constants of the 3x3 filter.
package c3f_pkg;
	localparam logic [2:0] KSEL_SMOOTH  = 3'd0;
	localparam logic [2:0] KSEL_BLUR    = 3'd1;
	localparam logic [2:0] KSEL_SHARPEN = 3'd2;
	localparam logic [2:0] KSEL_MEAN    = 3'd3;
	localparam logic [2:0] KSEL_EMBOSS  = 3'd4;

	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_MAXLVL = 3'd2;
	localparam logic [2:0] REG_KSEL   = 3'd3;
	localparam logic [2:0] REG_GREY   = 3'd4;

	// Classified item handed from front to back.
	typedef struct packed {
		logic [8:0] mask;      // tap enable, index row*3+col
		logic       last;
		logic [23:0] px;       // incoming pixel (right column bottom)
		logic [23:0] top;
		logic [23:0] mid;
		logic       valid;     // produces a result
		logic       shift;     // advance window
	} item_t;

	// Kernel weight per tap.
	function automatic logic signed [4:0] kern_w(input logic [2:0] k, input int t);
		logic signed [4:0] w;
		w = 5'sd0;
		unique case (k)
			KSEL_SMOOTH: w = 5'sd1;
			KSEL_BLUR: w = (t == 4) ? 5'sd4 : ((t % 2) == 1 ? 5'sd2 : 5'sd1);
			KSEL_SHARPEN: w = (t == 4) ? 5'sd11 : ((t % 2) == 1 ? -5'sd2 : 5'sd0);
			KSEL_MEAN: w = (t == 4) ? 5'sd9 : -5'sd1;
			KSEL_EMBOSS: w = (t == 1) ? -5'sd1 : ((t == 7) ? 5'sd1 : 5'sd0);
			default: w = 5'sd0;
		endcase
		return w;
	endfunction
endpackage

// ----- hw/rtl/conv3x3_image_filter_core.sv -----
// Path: front read stage, queue, sum stage and divide/clamp stage (plus one row of delay).
// Throughput: one pixel per cycle while the output is not stalled, set by the single-port-per-cycle line stores.
// Each item takes one line-store read and write, then two arithmetic stages.
// Reset: arst_n clears positions, window, queue and registers to their defaults.
// Line stores need no clearing pass; unwritten entries only feed padded taps.
module conv3x3_image_filter_core import c3f_pkg::*; #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
	input  logic        s_tuser,   // flush
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // red_out, green_out, blue_out
	output logic        m_tlast    // frame_end
);
	logic [11:0] width_q, height_q;
	logic [7:0]  maxl_q;
	logic [2:0]  ksel_q;
	logic        grey_q;
	logic        wr, pos_clr;
	logic        f_v, f_r, b_v, b_r;
	item_t       f_item, b_item;
	logic [24:0] odata;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign pos_clr = wr && (paddr[4:2] == REG_WIDTH || paddr[4:2] == REG_HEIGHT);

	// register file writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 12'd640;
			height_q <= 12'd480;
			maxl_q <= 8'd255;
			ksel_q <= KSEL_SMOOTH;
			grey_q <= 1'b0;
		end else if (wr) begin
			unique case (paddr[4:2])
				REG_WIDTH: width_q <= pwdata[11:0];
				REG_HEIGHT: height_q <= pwdata[11:0];
				REG_MAXLVL: maxl_q <= pwdata[7:0];
				REG_KSEL: ksel_q <= pwdata[2:0];
				REG_GREY: grey_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_WIDTH: prdata = {20'd0, width_q};
			REG_HEIGHT: prdata = {20'd0, height_q};
			REG_MAXLVL: prdata = {24'd0, maxl_q};
			REG_KSEL: prdata = {29'd0, ksel_q};
			REG_GREY: prdata = {31'd0, grey_q};
			default: prdata = '0;
		endcase
	end

	c3f_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_px(s_tuser ? 24'd0 : s_tdata),
		.pos_clr(pos_clr), .w_raw(width_q), .h_raw(height_q),
		.out_valid(f_v), .out_ready(f_r), .out_item(f_item)
	);

	c3f_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_v), .wr_ready(f_r), .wr_item(f_item),
		.rd_valid(b_v), .rd_ready(b_r), .rd_item(b_item)
	);

	c3f_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(b_v), .in_ready(b_r), .in_item(b_item),
		.max_level(maxl_q), .ksel(ksel_q), .grey(grey_q),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_data(odata)
	);

	assign m_tdata = odata[23:0];
	assign m_tlast = odata[24];
endmodule

// ----- hw/rtl/c3f_front.sv -----
// Front: position tracking, line stores and tap classification.
`include "conv3x3_image_filter_core_macros.svh"
module c3f_front import c3f_pkg::*; #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [23:0] in_px,
	input  logic        pos_clr,
	input  logic [11:0] w_raw,
	input  logic [11:0] h_raw,
	output logic        out_valid,
	input  logic        out_ready,
	output item_t       out_item
);
	localparam int AW = $clog2(MAX_WIDTH);

	logic [23:0] mem_a [MAX_WIDTH];
	logic [23:0] mem_b [MAX_WIDTH];
	logic [11:0] row_q;
	logic [12:0] col_q;
	logic [13:0] w_eff, h_eff;
	logic [13:0] c, pr, pc;
	logic        valid, last;
	logic [8:0]  mask;

	// stage 1: address presented, reads registered
	logic        v_s1;
	logic [23:0] px_s1, top_s1, mid_s1;
	logic        val_s1, last_s1;
	logic [8:0]  mask_s1;
	logic        adv;

	always_comb begin
		w_eff = (w_raw == 12'd0) ? 14'd1 :
			((14'(w_raw) > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : 14'(w_raw));
		h_eff = (h_raw == 12'd0) ? 14'd1 :
			((14'(h_raw) > 14'(MAX_HEIGHT)) ? 14'(MAX_HEIGHT) : 14'(h_raw));
		c = (14'(col_q) >= w_eff) ? 14'd0 : 14'(col_q);
		valid = 1'b0;
		pr = 14'd0;
		if (c != 14'd0) begin
			pc = c - 14'd1;
			if (row_q >= 12'd1 && 14'(row_q) - 14'd1 < h_eff) begin
				pr = 14'(row_q) - 14'd1;
				valid = 1'b1;
			end
		end else begin
			pc = w_eff - 14'd1;
			if (row_q >= 12'd2 && 14'(row_q) - 14'd2 < h_eff) begin
				pr = 14'(row_q) - 14'd2;
				valid = 1'b1;
			end
		end
		last = (pr == h_eff - 14'd1) && (pc == w_eff - 14'd1);
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				mask[i*3+j] = !((i == 0 && pr == 14'd0) || (i == 2 && pr == h_eff - 14'd1) ||
					(j == 0 && pc == 14'd0) || (j == 2 && pc == w_eff - 14'd1));
			end
		end
	end

	assign adv = !v_s1 || out_ready;
	assign in_ready = adv;

	// advance positions on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			if (adv) v_s1 <= in_valid;
			if (pos_clr) begin
				row_q <= '0;
				col_q <= '0;
			end else if (in_valid && adv) begin
				if (valid && last) begin
					row_q <= '0;
					col_q <= '0;
				end else if (c + 14'd1 >= w_eff) begin
					col_q <= '0;
					if (row_q < 12'd4095) row_q <= row_q + 12'd1;
				end else begin
					col_q <= 13'(c + 14'd1);
				end
			end
		end
	end

	// line stores: read old, write shifted
	always_ff @(posedge clk) begin
		if (in_valid && adv) begin
			top_s1 <= mem_b[c[AW-1:0]];
			mid_s1 <= mem_a[c[AW-1:0]];
			mem_b[c[AW-1:0]] <= mem_a[c[AW-1:0]];
			mem_a[c[AW-1:0]] <= in_px;
			px_s1 <= in_px;
			val_s1 <= valid;
			last_s1 <= last;
			mask_s1 <= mask;
		end
	end

	always_comb begin
		out_valid = v_s1;
		out_item.mask = mask_s1;
		out_item.last = last_s1;
		out_item.px = px_s1;
		out_item.top = top_s1;
		out_item.mid = mid_s1;
		out_item.valid = val_s1;
		out_item.shift = 1'b1;
	end

	`C3_ASSERT_NEXT(a_hold, clk, arst_n, v_s1 && !out_ready, v_s1)
	`C3_ASSERT_IMPL(a_col, clk, arst_n, 1'b1, col_q <= 13'(MAX_WIDTH))
	`C3_ASSERT_IMPL(a_rdy, clk, arst_n, !v_s1, in_ready)
endmodule

// ----- hw/rtl/c3f_queue.sv -----
// Small two-entry queue between front and back.
`include "conv3x3_image_filter_core_macros.svh"
module c3f_queue import c3f_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	output logic  wr_ready,
	input  item_t wr_item,
	output logic  rd_valid,
	input  logic  rd_ready,
	output item_t rd_item
);
	item_t      buf_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_item = buf_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) buf_q[wp_q] <= wr_item;
	end

	// track fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	`C3_ASSERT_IMPL(a_cnt, clk, arst_n, 1'b1, cnt_q <= 2'd2)
	`C3_ASSERT_NEXT(a_full, clk, arst_n, cnt_q == 2'd2 && !rd, cnt_q == 2'd2)
	`C3_ASSERT_IMPL(a_ptr, clk, arst_n, cnt_q == 2'd0 || cnt_q == 2'd2, wp_q == rp_q)
endmodule

// ----- hw/rtl/c3f_back.sv -----
// Back: window registers, weighted sum, divide and clamp.
`include "conv3x3_image_filter_core_macros.svh"
module c3f_back import c3f_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  item_t       in_item,
	input  logic [7:0]  max_level,
	input  logic [2:0]  ksel,
	input  logic        grey,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [24:0] out_data
);
	logic [23:0] win_q [9];
	logic        adv;
	logic        take;
	logic        v_s1, v_s2;
	logic signed [13:0] sum_s1 [3];
	logic signed [13:0] sum_nx [3];
	logic        last_s1, last_s2;
	logic [7:0]  res_s2 [3];
	logic [23:0] nw [9];
	logic [7:0]  res [3];
	logic signed [13:0] s;
	logic [13:0] q;
	logic [28:0] prod;

	assign adv = !v_s2 || out_ready;
	assign in_ready = adv;
	assign take = in_valid && adv;

	// next window after a shift
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nw[i*3]   = win_q[i*3+1];
			nw[i*3+1] = win_q[i*3+2];
		end
		nw[2] = in_item.top;
		nw[5] = in_item.mid;
		nw[8] = in_item.px;
	end

	// window shift: reset value zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < 9; t++) win_q[t] <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid && in_item.valid;
			v_s2 <= v_s1;
			if (take) begin
				for (int t = 0; t < 9; t++) win_q[t] <= nw[t];
			end
		end
	end

	// masked weighted sums over the next window
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum_nx[ch] = '0;
			for (int t = 0; t < 9; t++) begin
				if (in_item.mask[t])
					sum_nx[ch] = sum_nx[ch] + 14'(kern_w(ksel, t)) *
						$signed({6'd0, nw[t][ch*8 +: 8]});
			end
		end
	end

	// stage 1: register the sums
	always_ff @(posedge clk) begin
		if (take) begin
			last_s1 <= in_item.last;
			for (int ch = 0; ch < 3; ch++) sum_s1[ch] <= sum_nx[ch];
		end
	end

	// stage 2: divide by reciprocal or shift, then clamp
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			s = sum_s1[ch];
			prod = '0;
			unique case (ksel)
				KSEL_SMOOTH: begin
					prod = 29'(s[12:0]) * 29'd7282;
					q = 14'(prod >> 16);
				end
				KSEL_BLUR: q = 14'(s[12:4]);
				KSEL_SHARPEN: begin
					prod = 29'(s[12:0]) * 29'd21846;
					q = 14'(prod >> 16);
				end
				default: q = 14'(s[12:0]);
			endcase
			if (ksel > KSEL_EMBOSS || s < 0) res[ch] = 8'd0;
			else if (q >= 14'd255 || q >= 14'(max_level)) res[ch] = max_level;
			else res[ch] = q[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s2 <= last_s1;
			res_s2[0] <= res[0];
			res_s2[1] <= grey ? 8'd0 : res[1];
			res_s2[2] <= grey ? 8'd0 : res[2];
		end
	end

	assign out_valid = v_s2;
	assign out_data = {last_s2, res_s2[2], res_s2[1], res_s2[0]};

	`C3_ASSERT_NEXT(a_stall, clk, arst_n, v_s2 && !out_ready, v_s2 && $stable(out_data))
	`C3_ASSERT_IMPL(a_grey, clk, arst_n, v_s2 && grey, out_data[23:8] == 16'd0)
	`C3_ASSERT_IMPL(a_clamp, clk, arst_n, v_s2, out_data[7:0] <= max_level || out_data[7:0] == 8'd0)
endmodule
